>>> rtl/core/ansi_escape_console_filter_assert.svh
// assertion helpers shared by the console filter
`ifndef ANSI_ESCAPE_CONSOLE_FILTER_ASSERT_SVH
`define ANSI_ESCAPE_CONSOLE_FILTER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define ACF_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define ACF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/acf_pkg.sv
package acf_pkg;

    localparam logic [7:0] ESC_BYTE   = 8'h1B;
    localparam logic [7:0] FINAL_LOW  = 8'h40;
    localparam logic [7:0] FINAL_HIGH = 8'h7E;
    localparam logic [7:0] CR_BYTE    = 8'h0D;
    localparam logic [7:0] LF_BYTE    = 8'h0A;
    localparam logic [7:0] LBRACK     = 8'h5B;
    localparam logic [7:0] CHAR_J     = 8'h4A;
    localparam logic [7:0] CHAR_K     = 8'h4B;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_2     = 8'h32;

    localparam int MAX_RES = 3;

    typedef enum logic [1:0] {
        ACT_APPEND = 2'd0,
        ACT_CLEAR  = 2'd1,
        ACT_HOME   = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_ESC  = 2'd1,
        MODE_CSI  = 2'd2
    } mode_t;

    // all results caused by one input byte
    typedef struct packed {
        logic [MAX_RES-1:0][1:0] act;
        logic [MAX_RES-1:0][7:0] chr;
        logic [1:0]              cnt;
    } bundle_t;

    function automatic bundle_t emit(bundle_t b, action_t a, logic [7:0] ch);
        bundle_t r;
        r = b;
        if (b.cnt < 2'(MAX_RES)) begin
            r.act[b.cnt] = a;
            r.chr[b.cnt] = ch;
            r.cnt        = b.cnt + 2'd1;
        end
        return r;
    endfunction

endpackage

>>> rtl/core/acf_front.sv
module acf_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_accept,
    input  logic [7:0]         char_in,
    input  logic               chunk_end,
    output logic               push,
    output acf_pkg::bundle_t   push_data
);

    acf_pkg::mode_t mode_reg, mode_next;
    logic [1:0]     pc_reg, pc_next;
    logic [7:0]     fp_reg, fp_next;
    logic           crp_reg, crp_next;
    acf_pkg::bundle_t bnd;

    always_comb begin
        logic run_idle;
        run_idle  = 1'b0;
        mode_next = mode_reg;
        pc_next   = pc_reg;
        fp_next   = fp_reg;
        crp_next  = crp_reg;
        bnd       = '0;

        case (mode_reg)
            acf_pkg::MODE_ESC: begin
                if (char_in == acf_pkg::LBRACK) begin
                    mode_next = acf_pkg::MODE_CSI;
                    pc_next   = 2'd0;
                    fp_next   = 8'd0;
                end else begin
                    mode_next = acf_pkg::MODE_IDLE;
                    // held escape goes out as a plain byte
                    if (crp_next) begin
                        bnd      = acf_pkg::emit(bnd, acf_pkg::ACT_HOME, 8'd0);
                        crp_next = 1'b0;
                    end
                    bnd      = acf_pkg::emit(bnd, acf_pkg::ACT_APPEND, acf_pkg::ESC_BYTE);
                    run_idle = 1'b1;
                end
            end
            acf_pkg::MODE_CSI: begin
                if (char_in inside {[acf_pkg::FINAL_LOW:acf_pkg::FINAL_HIGH]}) begin
                    mode_next = acf_pkg::MODE_IDLE;
                    if (char_in == acf_pkg::CHAR_J && pc_reg == 2'd1
                            && fp_reg == acf_pkg::CHAR_2) begin
                        crp_next = 1'b0;
                        bnd      = acf_pkg::emit(bnd, acf_pkg::ACT_CLEAR, 8'd0);
                    end else if (char_in == acf_pkg::CHAR_K && (pc_reg != 2'd1
                            || fp_reg == acf_pkg::CHAR_0 || fp_reg == acf_pkg::CHAR_2)) begin
                        // erase line acts as a carriage return
                        if (crp_next) bnd = acf_pkg::emit(bnd, acf_pkg::ACT_HOME, 8'd0);
                        crp_next = 1'b1;
                    end
                    pc_next = 2'd0;
                    fp_next = 8'd0;
                end else begin
                    if (pc_reg == 2'd0) fp_next = char_in;
                    if (pc_reg < 2'd2) pc_next = pc_reg + 2'd1;
                end
            end
            default: begin
                mode_next = acf_pkg::MODE_IDLE;
                run_idle  = 1'b1;
            end
        endcase

        if (run_idle) begin
            if (char_in == acf_pkg::ESC_BYTE) begin
                mode_next = acf_pkg::MODE_ESC;
            end else if (char_in == acf_pkg::CR_BYTE) begin
                if (crp_next) bnd = acf_pkg::emit(bnd, acf_pkg::ACT_HOME, 8'd0);
                crp_next = 1'b1;
            end else begin
                if (crp_next) begin
                    if (char_in != acf_pkg::LF_BYTE)
                        bnd = acf_pkg::emit(bnd, acf_pkg::ACT_HOME, 8'd0);
                    crp_next = 1'b0;
                end
                bnd = acf_pkg::emit(bnd, acf_pkg::ACT_APPEND, char_in);
            end
        end

        if (chunk_end) begin
            if (mode_next == acf_pkg::MODE_ESC) begin
                if (crp_next) begin
                    bnd      = acf_pkg::emit(bnd, acf_pkg::ACT_HOME, 8'd0);
                    crp_next = 1'b0;
                end
                bnd = acf_pkg::emit(bnd, acf_pkg::ACT_APPEND, acf_pkg::ESC_BYTE);
            end
            mode_next = acf_pkg::MODE_IDLE;
            pc_next   = 2'd0;
            fp_next   = 8'd0;
            if (crp_next) begin
                bnd      = acf_pkg::emit(bnd, acf_pkg::ACT_HOME, 8'd0);
                crp_next = 1'b0;
            end
        end
    end

    assign push      = in_accept && (bnd.cnt != 2'd0);
    assign push_data = bnd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= acf_pkg::MODE_IDLE;
            pc_reg   <= 2'd0;
            fp_reg   <= 8'd0;
            crp_reg  <= 1'b0;
        end else if (in_accept) begin
            mode_reg <= mode_next;
            pc_reg   <= pc_next;
            fp_reg   <= fp_next;
            crp_reg  <= crp_next;
        end
    end

endmodule

>>> rtl/core/acf_queue.sv
module acf_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  acf_pkg::bundle_t push_data,
    input  logic             pop,
    output acf_pkg::bundle_t pop_data,
    output logic             full,
    output logic             not_empty
);

    acf_pkg::bundle_t slot_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) slot_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (do_push) wr_ptr_reg <= ~wr_ptr_reg;
            if (do_pop)  rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + 2'(do_push) - 2'(do_pop);
        end
    end

endmodule

>>> rtl/core/acf_back.sv
module acf_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_valid,
    input  acf_pkg::bundle_t q_data,
    output logic             q_pop,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [1:0]       m_action,
    output logic [7:0]       m_char,
    output logic             m_last
);

    acf_pkg::bundle_t cur_reg;
    logic             cur_valid_reg;
    logic [1:0]       idx_reg;
    logic             m_valid_reg;
    logic [1:0]       act_reg;
    logic [7:0]       chr_reg;
    logic             last_reg;
    logic             out_free;
    logic             cur_last;
    logic             cur_done;

    assign out_free = !m_valid_reg || m_ready;
    assign cur_last = (idx_reg == cur_reg.cnt - 2'd1);
    assign cur_done = cur_valid_reg && out_free && cur_last;
    assign q_pop    = q_valid && (!cur_valid_reg || cur_done);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (q_pop) begin
                cur_valid_reg <= 1'b1;
                idx_reg       <= 2'd0;
            end else if (cur_done) begin
                cur_valid_reg <= 1'b0;
            end else if (cur_valid_reg && out_free) begin
                idx_reg <= idx_reg + 2'd1;
            end
            if (out_free) m_valid_reg <= cur_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) cur_reg <= q_data;
        if (out_free && cur_valid_reg) begin
            act_reg  <= cur_reg.act[idx_reg];
            chr_reg  <= cur_reg.chr[idx_reg];
            last_reg <= cur_last;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_action = act_reg;
    assign m_char   = chr_reg;
    assign m_last   = last_reg;

endmodule

>>> rtl/core/ansi_escape_console_filter.sv
// Console byte filter: takes one raw byte per cycle on the s_ side while s_tready is high
// (tlast marks the end of a drain chunk) and emits screen edit words on the m_ side: append
// a byte, clear the screen, or return to line start. ESC[2J clears, erase-line forms of
// ESC[K act as a carriage return, other CSI sequences are dropped, and CR right before LF
// is dropped. A byte may cause zero to three result words; the result port sends one word
// per cycle while m_tready is high, so a stream of single-result bytes runs at one byte
// per cycle, and a byte with n results holds the result port for n words. The first word
// of a byte passes the two-entry queue of per-byte result groups, the current group register
// and the output register on its way to m_tvalid. tready drops only when that queue is full.
`include "ansi_escape_console_filter_assert.svh"

module ansi_escape_console_filter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // char_in
    input  logic        s_tlast,   // chunk_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // char_out
    output logic [1:0]  m_tuser,   // action
    output logic        m_tlast    // last
);

    logic             in_accept;
    logic             push;
    acf_pkg::bundle_t push_data;
    logic             q_pop;
    acf_pkg::bundle_t q_data;
    logic             q_full;
    logic             q_valid;
    logic [1:0]       action;
    logic [7:0]       char_out;
    logic             cmd_word;

    assign s_tready  = !q_full;
    assign in_accept = s_tvalid && s_tready;

    acf_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .char_in   (s_tdata),
        .chunk_end (s_tlast),
        .push      (push),
        .push_data (push_data)
    );

    acf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (q_pop),
        .pop_data  (q_data),
        .full      (q_full),
        .not_empty (q_valid)
    );

    acf_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .q_pop    (q_pop),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_action (action),
        .m_char   (char_out),
        .m_last   (m_tlast)
    );

    assign m_tdata  = char_out;
    assign m_tuser  = action;
    assign cmd_word = m_tvalid && (action != acf_pkg::ACT_APPEND);

    `ACF_ASSERT_IMPLIES(a_action_legal, m_tvalid, action != 2'd3, "illegal action code")
    `ACF_ASSERT_IMPLIES(a_cmd_no_char, cmd_word, char_out == 8'd0, "command word carries a byte")
    `ACF_ASSERT_IMPLIES(a_no_push_when_full, q_full, !in_accept, "byte taken with queue full")
    `ACF_ASSERT_NEXT(a_word_held, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled word changed")

endmodule
